/* rtl/core/pdbd_pkg.sv */
// Shared constants, register indexes and controller/datapath struct types.
`timescale 1ns / 1ps
`default_nettype none

package pdbd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_THR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_TMO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TMO   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_SHIFT = 3'd5;

	localparam int FREQ_W  = 16;
	localparam int DUTY_W  = 7;
	localparam int TMO_W   = 16;
	localparam int SHIFT_W = 3;

	localparam logic [FREQ_W-1:0]  FREQ_LOW_RST   = 16'd190;
	localparam logic [FREQ_W-1:0]  FREQ_HIGH_RST  = 16'd220;
	localparam logic [DUTY_W-1:0]  DUTY_THR_RST   = 7'd80;
	localparam logic [TMO_W-1:0]   LOW_TMO_RST    = 16'd40000;
	localparam logic [TMO_W-1:0]   HIGH_TMO_RST   = 16'd40000;
	localparam logic [SHIFT_W-1:0] TICK_SHIFT_RST = 3'd3;

	// Idle run counters saturate at full scale
	localparam int               IDLE_W   = 16;
	localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hffff;

	// Division constants: frequency numerator and duty scale
	localparam int FREQ_NUM     = 1000000;
	localparam int FREQ_NUM_W   = 20;
	localparam int DUTY_SCALE   = 100;
	localparam int DUTY_SCALE_W = 7;

	typedef struct packed {
		logic accept;       // sample word taken this cycle
		logic load_freq;    // start 1e6 / period
		logic load_duty;    // start high*100 / period
		logic step;         // one restoring divide step
		logic finish_zero;  // end measurement with brake low
		logic finish_duty;  // end measurement with brake from duty compare
	} pdbd_cmd_t;

	typedef struct packed {
		logic out_free;       // result register empty or being drained
		logic need_div;       // current sample closes a period
		logic period_zero;    // scaled period is zero
		logic div_last;       // divider on its final step
		logic freq_in_window; // quotient strictly inside the frequency window
	} pdbd_status_t;

endpackage

`default_nettype wire

/* rtl/core/pdbd_if.sv */
// Valid/ready channel interfaces for sample words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface pdbd_in_if;
	logic valid;
	logic ready;
	logic pwm_level;

	modport source (output valid, output pwm_level, input ready);
	modport sink   (input valid, input pwm_level, output ready);
endinterface

interface pdbd_out_if;
	logic valid;
	logic ready;
	logic pos_out;
	logic brake_out;
	logic measure_done;

	modport source (output valid, output pos_out, output brake_out, output measure_done,
		input ready);
	modport sink   (input valid, input pos_out, input brake_out, input measure_done,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/pwm_duty_brake_detector_unit.sv */
// Top level of the PWM duty brake detector: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Word                                | Handshake
// ----------+-----+-------------------------------------+-----------
// samples   | in  | pwm_level (1 bit, one per tick)     | valid/ready
// results   | out | pos_out, brake_out, measure_done    | valid/ready
// cfg_*     | in  | cfg_index, cfg_wdata (16 bit)       | cfg_we only
//
// A sample that does not close a period has its result word in the output register
// in the cycle after it is taken. A falling edge after a rise runs a restoring
// divider one quotient bit a cycle over DW = max(20, COUNT_WIDTH+7) bits: a zero
// period finishes without dividing, a frequency outside the window ends after the
// frequency division, and otherwise the duty division also runs.
// Reset clears all control state and restores the register defaults at once.
// While a result word waits unread, samples are held off.

module pwm_duty_brake_detector_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pdbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pdbd_in_if.sink                              samples,
	pdbd_out_if.source                           results
);
	import pdbd_pkg::*;

	pdbd_cmd_t    cmd;
	pdbd_status_t st;
	logic         in_ready;
	logic         out_valid, pos_out, brake_out, measure_done;

	// Sequence accept, divide and finish
	pdbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// Hold the measurement state, the divider and the result word
	pdbd_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_level     (samples.pwm_level),
		.out_ready    (results.ready),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.pos_out      (pos_out),
		.brake_out    (brake_out),
		.measure_done (measure_done)
	);

	assign samples.ready        = in_ready;
	assign results.valid        = out_valid;
	assign results.pos_out      = pos_out;
	assign results.brake_out    = brake_out;
	assign results.measure_done = measure_done;

endmodule

`default_nettype wire

/* rtl/core/pdbd_ctrl.sv */
// Controller state machine sequencing sample acceptance and the two divisions.
`timescale 1ns / 1ps
`default_nettype none

module pdbd_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire pdbd_pkg::pdbd_status_t st,
	output logic                       in_ready,
	output pdbd_pkg::pdbd_cmd_t        cmd
);
	import pdbd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV_F,
		S_CHK_F,
		S_DIV_D,
		S_CHK_D
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) && st.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && st.need_div) state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= st.period_zero ? S_IDLE : S_DIV_F;
				end
				S_DIV_F: begin
					if (st.div_last) state_q <= S_CHK_F;
				end
				S_CHK_F: begin
					state_q <= st.freq_in_window ? S_DIV_D : S_IDLE;
				end
				S_DIV_D: begin
					if (st.div_last) state_q <= S_CHK_D;
				end
				S_CHK_D: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.accept      = accept;
		unique case (state_q)
			S_IDLE: begin
			end
			S_PREP: begin
				cmd.finish_zero = st.period_zero;
				cmd.load_freq   = !st.period_zero;
			end
			S_DIV_F, S_DIV_D: begin
				cmd.step = 1'b1;
			end
			S_CHK_F: begin
				cmd.load_duty   = st.freq_in_window;
				cmd.finish_zero = !st.freq_in_window;
			end
			S_CHK_D: begin
				cmd.finish_duty = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/pdbd_datapath.sv */
// Datapath: config registers, edge and idle counters, divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module pdbd_datapath #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pdbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                          in_level,
	input  wire logic                          out_ready,
	input  wire pdbd_pkg::pdbd_cmd_t           cmd,
	output pdbd_pkg::pdbd_status_t             st,
	output logic                               out_valid,
	output logic                               pos_out,
	output logic                               brake_out,
	output logic                               measure_done
);
	import pdbd_pkg::*;

	localparam int PW = COUNT_WIDTH + 1;
	localparam int DW = (COUNT_WIDTH + DUTY_SCALE_W > FREQ_NUM_W) ?
		(COUNT_WIDTH + DUTY_SCALE_W) : FREQ_NUM_W;
	localparam int CNT_W = $clog2(DW);

	// Configuration
	logic [FREQ_W-1:0]  freq_low_q, freq_high_q;
	logic [DUTY_W-1:0]  duty_thr_q;
	logic [TMO_W-1:0]   low_tmo_q, high_tmo_q;
	logic [SHIFT_W-1:0] tick_shift_q;

	// Measurement state
	logic                   prev_q, rise_q, pos_q, brake_q;
	logic [COUNT_WIDTH-1:0] ewc_q, low_width_q;
	logic [IDLE_W-1:0]      low_idle_q, high_idle_q;

	// Divider
	logic [COUNT_WIDTH-1:0] hi_us_q;
	logic [PW-1:0]          period_q;
	logic [PW-1:0]          rem_q;
	logic [DW-1:0]          dq_q;
	logic [CNT_W-1:0]       cnt_q;

	// Result register
	logic out_valid_q, pos_out_q, brake_out_q, done_q;

	logic                   edge_w, measure_w, hi_to_w, lo_to_w;
	logic                   pos_next_w, brake_next_w, duty_ge_w;
	logic [COUNT_WIDTH-1:0] width_w, lo_us_w, hi_us_w;
	logic [IDLE_W-1:0]      high_next_w, low_next_w;
	logic [PW:0]            rem_sh_w;
	logic                   ge_w;
	logic [PW:0]            diff_w;
	logic [DW-1:0]          hi_scaled_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_low_q   <= FREQ_LOW_RST;
			freq_high_q  <= FREQ_HIGH_RST;
			duty_thr_q   <= DUTY_THR_RST;
			low_tmo_q    <= LOW_TMO_RST;
			high_tmo_q   <= HIGH_TMO_RST;
			tick_shift_q <= TICK_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FREQ_LOW:   freq_low_q   <= cfg_wdata[FREQ_W-1:0];
				CFG_FREQ_HIGH:  freq_high_q  <= cfg_wdata[FREQ_W-1:0];
				CFG_DUTY_THR:   duty_thr_q   <= cfg_wdata[DUTY_W-1:0];
				CFG_LOW_TMO:    low_tmo_q    <= cfg_wdata[TMO_W-1:0];
				CFG_HIGH_TMO:   high_tmo_q   <= cfg_wdata[TMO_W-1:0];
				CFG_TICK_SHIFT: tick_shift_q <= cfg_wdata[SHIFT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		edge_w    = in_level != prev_q;
		width_w   = ewc_q + 1'b1;
		measure_w = edge_w && !in_level && rise_q;

		if (!in_level)               high_next_w = '0;
		else if (high_idle_q == IDLE_MAX) high_next_w = high_idle_q;
		else                         high_next_w = high_idle_q + 1'b1;

		if (in_level)                low_next_w = '0;
		else if (low_idle_q == IDLE_MAX) low_next_w = low_idle_q;
		else                         low_next_w = low_idle_q + 1'b1;

		hi_to_w = in_level && (high_next_w >= high_tmo_q);
		lo_to_w = !in_level && (low_next_w >= low_tmo_q);

		// Timeouts override whatever the edge did this tick
		priority if (hi_to_w) begin
			pos_next_w   = 1'b1;
			brake_next_w = 1'b1;
		end else if (lo_to_w) begin
			pos_next_w   = 1'b0;
			brake_next_w = 1'b0;
		end else begin
			pos_next_w   = pos_q | (edge_w & in_level);
			brake_next_w = brake_q;
		end

		lo_us_w = low_width_q >> tick_shift_q;
		hi_us_w = width_w >> tick_shift_q;

		rem_sh_w    = {rem_q, dq_q[DW-1]};
		ge_w        = rem_sh_w >= {1'b0, period_q};
		diff_w      = rem_sh_w - {1'b0, period_q};
		hi_scaled_w = DW'(hi_us_q) * DW'(DUTY_SCALE);
		duty_ge_w   = dq_q >= DW'(duty_thr_q);
	end

	always_comb begin
		st                = '0;
		st.out_free       = !out_valid_q || out_ready;
		st.need_div       = measure_w && !lo_to_w;
		st.period_zero    = period_q == '0;
		st.div_last       = cnt_q == CNT_W'(DW - 1);
		st.freq_in_window = (dq_q > DW'(freq_low_q)) && (dq_q < DW'(freq_high_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			rise_q      <= 1'b0;
			pos_q       <= 1'b0;
			brake_q     <= 1'b0;
			ewc_q       <= '0;
			low_width_q <= '0;
			low_idle_q  <= '0;
			high_idle_q <= '0;
		end else if (cmd.accept) begin
			prev_q      <= in_level;
			low_idle_q  <= low_next_w;
			high_idle_q <= high_next_w;
			pos_q       <= pos_next_w;
			brake_q     <= brake_next_w;
			ewc_q       <= edge_w ? '0 : width_w;
			if (edge_w && in_level) begin
				low_width_q <= width_w;
				rise_q      <= 1'b1;
			end else if (measure_w) begin
				rise_q <= 1'b0;
			end
		end else if (cmd.finish_zero) begin
			brake_q <= 1'b0;
		end else if (cmd.finish_duty) begin
			brake_q <= duty_ge_w;
		end
	end

	// Divider operands and restoring steps
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hi_us_q  <= hi_us_w;
			period_q <= {1'b0, lo_us_w} + {1'b0, hi_us_w};
		end
		if (cmd.load_freq || cmd.load_duty) begin
			rem_q <= '0;
			cnt_q <= '0;
			dq_q  <= cmd.load_freq ? DW'(FREQ_NUM) : hi_scaled_w;
		end else if (cmd.step) begin
			rem_q <= ge_w ? diff_w[PW-1:0] : rem_sh_w[PW-1:0];
			dq_q  <= {dq_q[DW-2:0], ge_w};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.accept && !st.need_div) || cmd.finish_zero || cmd.finish_duty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !st.need_div) begin
			pos_out_q   <= pos_next_w;
			brake_out_q <= brake_next_w;
			done_q      <= measure_w;
		end else if (cmd.finish_zero || cmd.finish_duty) begin
			pos_out_q   <= pos_q;
			brake_out_q <= cmd.finish_duty && duty_ge_w;
			done_q      <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_out      = pos_out_q;
	assign brake_out    = brake_out_q;
	assign measure_done = done_q;

endmodule

`default_nettype wire

/* rtl/core/pdbd_checker.sv */
// Port-level checker for the brake detector and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pdbd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic in_level,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic pos_out,
	input wire logic brake_out,
	input wire logic measure_done
);

	// Stalled result word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_out) && $stable(brake_out)
			&& $stable(measure_done))
		else $error("result word changed while stalled");

	// No new sample while the result register is full and not drained
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("sample taken over an unread result");

	// A high sample never closes a period and always answers on the next edge
	a_high_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_level |=> out_valid && !measure_done)
		else $error("high sample gave a measurement or no result");

	// Brake only ever stands with position high
	a_brake_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brake_out |-> pos_out)
		else $error("brake high with position low");

endmodule

bind pwm_duty_brake_detector_unit pdbd_checker u_pdbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.in_level     (samples.pwm_level),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.pos_out      (results.pos_out),
	.brake_out    (results.brake_out),
	.measure_done (results.measure_done)
);

`default_nettype wire
